// ----- design/bmmd_pkg.sv -----
package bmmd_pkg;

    // Work RAM geometry
    localparam int WRAM_BANKS = 8;
    localparam int BANK_BYTES = 4096;
    localparam int BANK_W     = (WRAM_BANKS > 1) ? $clog2(WRAM_BANKS) : 1;
    localparam int WRAM_DEPTH = WRAM_BANKS * BANK_BYTES;
    localparam int WRAM_AW    = BANK_W + 12;

    // High RAM geometry
    localparam int HRAM_BYTES = 127;
    localparam int HRAM_AW    = $clog2(HRAM_BYTES);

    // Front/back queue
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Bus map
    localparam logic [15:0] ADDR_VRAM_LO  = 16'h8000;
    localparam logic [15:0] ADDR_VRAM_HI  = 16'h9FFF;
    localparam logic [15:0] ADDR_WRAM_LO  = 16'hC000;
    localparam logic [15:0] ADDR_ECHO_HI  = 16'hFDFF;
    localparam logic [15:0] ADDR_OAM_LO   = 16'hFE00;
    localparam logic [15:0] ADDR_OAM_HI   = 16'hFE9F;
    localparam logic [15:0] ADDR_HOLE_LO  = 16'hFEA0;
    localparam logic [15:0] ADDR_HOLE_HI  = 16'hFEFF;
    localparam logic [15:0] ADDR_JOYP     = 16'hFF00;
    localparam logic [15:0] ADDR_SB       = 16'hFF01;
    localparam logic [15:0] ADDR_SC       = 16'hFF02;
    localparam logic [15:0] ADDR_TIM_LO   = 16'hFF04;
    localparam logic [15:0] ADDR_TIM_HI   = 16'hFF07;
    localparam logic [15:0] ADDR_IF       = 16'hFF0F;
    localparam logic [15:0] ADDR_SND_LO   = 16'hFF10;
    localparam logic [15:0] ADDR_SND_HI   = 16'hFF3F;
    localparam logic [15:0] ADDR_LCD_LO   = 16'hFF40;
    localparam logic [15:0] ADDR_LCD_HI   = 16'hFF4B;
    localparam logic [15:0] ADDR_DMA      = 16'hFF46;
    localparam logic [15:0] ADDR_KEY1     = 16'hFF4D;
    localparam logic [15:0] ADDR_VBK      = 16'hFF4F;
    localparam logic [15:0] ADDR_BOOT     = 16'hFF50;
    localparam logic [15:0] ADDR_HDMA1    = 16'hFF51;
    localparam logic [15:0] ADDR_HDMA2    = 16'hFF52;
    localparam logic [15:0] ADDR_HDMA3    = 16'hFF53;
    localparam logic [15:0] ADDR_HDMA4    = 16'hFF54;
    localparam logic [15:0] ADDR_HDMA5    = 16'hFF55;
    localparam logic [15:0] ADDR_PAL_LO   = 16'hFF68;
    localparam logic [15:0] ADDR_PAL_HI   = 16'hFF6B;
    localparam logic [15:0] ADDR_SVBK     = 16'hFF70;
    localparam logic [15:0] ADDR_HRAM_LO  = 16'hFF80;
    localparam logic [15:0] ADDR_HRAM_HI  = 16'hFFFE;
    localparam logic [15:0] ADDR_IE       = 16'hFFFF;

    // Reset values and data constants
    localparam logic [2:0]  BANK_SEL_RST  = 3'd1;
    localparam logic [15:0] HDMA_DST_RST  = 16'h8000;
    localparam logic [7:0]  OAM_PAGE_MOD  = 8'hE0;
    localparam logic [7:0]  RD_ALL_ONES   = 8'hFF;

    typedef enum logic [1:0] {
        CMD_READ      = 2'd0,
        CMD_WRITE     = 2'd1,
        CMD_SPEED     = 2'd2,
        CMD_HDMA_DONE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        TGT_INTERNAL = 3'd0,
        TGT_VIDEO    = 3'd1,
        TGT_SPRITE   = 3'd2,
        TGT_JOYPAD   = 3'd3,
        TGT_TIMER    = 3'd4,
        TGT_AUDIO    = 3'd5,
        TGT_CART     = 3'd6
    } target_t;

    // What the back end does with a request
    typedef enum logic [3:0] {
        K_NONE,
        K_CONST_FF,
        K_WRAM,
        K_HRAM,
        K_IF,
        K_IE,
        K_KEY1,
        K_OAM,
        K_SRC_HI,
        K_SRC_LO,
        K_DST_HI,
        K_DST_LO,
        K_HDMA_CTRL,
        K_SVBK,
        K_SPEED,
        K_HDMA_DONE
    } op_kind_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [4:0]  irq_raise;
    } in_req_t;

    typedef struct packed {
        logic [7:0]  rdata;
        target_t     target;
        logic        oam_dma_start;
        logic [7:0]  oam_dma_page;
        logic        double_speed_out;
        logic [15:0] hdma_src_out;
        logic [15:0] hdma_dst_out;
        logic [6:0]  hdma_blocks_out;
        logic        hdma_hblank_out;
        logic        hdma_stopped_out;
    } res_t;

    // Classified request, front to back
    typedef struct packed {
        op_kind_t    kind;
        logic        wr;
        target_t     target;
        logic [12:0] addr;
        logic [7:0]  wdata;
        logic [4:0]  irq_raise;
    } op_t;

    // Switchable bank number modulo the bank count
    function automatic logic [2:0] bank_mod(input logic [2:0] b);
        logic [2:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b == 3'(i))
            begin
                r = 3'(i % WRAM_BANKS);
            end
        end
        return r;
    endfunction

endpackage

// ----- design/bmmd_front.sv -----
module bmmd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_data,
    input  logic              push,
    input  bmmd_pkg::in_req_t req,
    input  logic              q_full,
    output logic              q_push,
    output bmmd_pkg::op_t     q_op
);

    logic color_mode_reg;
    logic color_mode_next;

    function automatic bmmd_pkg::op_t decode(input bmmd_pkg::in_req_t r, input logic color);
        bmmd_pkg::op_t o;
        logic [15:0]   a;
        logic          wr;
        a           = r.addr;
        wr          = (r.cmd == bmmd_pkg::CMD_WRITE);
        o.kind      = bmmd_pkg::K_NONE;
        o.wr        = wr;
        o.target    = bmmd_pkg::TGT_INTERNAL;
        o.addr      = a[12:0];
        o.wdata     = r.wdata;
        o.irq_raise = r.irq_raise;
        case (r.cmd)
            bmmd_pkg::CMD_SPEED:
            begin
                if (color)
                begin
                    o.kind = bmmd_pkg::K_SPEED;
                end
            end
            bmmd_pkg::CMD_HDMA_DONE:
            begin
                o.kind = bmmd_pkg::K_HDMA_DONE;
            end
            default:
            begin
                if (a >= bmmd_pkg::ADDR_VRAM_LO && a <= bmmd_pkg::ADDR_VRAM_HI)
                    o.target = bmmd_pkg::TGT_VIDEO;
                else if (a >= bmmd_pkg::ADDR_WRAM_LO && a <= bmmd_pkg::ADDR_ECHO_HI)
                    o.kind = bmmd_pkg::K_WRAM;
                else if (a >= bmmd_pkg::ADDR_OAM_LO && a <= bmmd_pkg::ADDR_OAM_HI)
                    o.target = bmmd_pkg::TGT_SPRITE;
                else if (a >= bmmd_pkg::ADDR_HOLE_LO && a <= bmmd_pkg::ADDR_HOLE_HI)
                    o.kind = bmmd_pkg::K_NONE;
                else if (a == bmmd_pkg::ADDR_JOYP)
                    o.target = bmmd_pkg::TGT_JOYPAD;
                else if (a == bmmd_pkg::ADDR_SB || a == bmmd_pkg::ADDR_SC)
                    o.kind = bmmd_pkg::K_NONE;
                else if (a >= bmmd_pkg::ADDR_TIM_LO && a <= bmmd_pkg::ADDR_TIM_HI)
                    o.target = bmmd_pkg::TGT_TIMER;
                else if (a == bmmd_pkg::ADDR_IF)
                    o.kind = bmmd_pkg::K_IF;
                else if (a >= bmmd_pkg::ADDR_SND_LO && a <= bmmd_pkg::ADDR_SND_HI)
                    o.target = bmmd_pkg::TGT_AUDIO;
                else if (a == bmmd_pkg::ADDR_DMA)
                    o.kind = wr ? bmmd_pkg::K_OAM : bmmd_pkg::K_NONE;
                else if (a >= bmmd_pkg::ADDR_LCD_LO && a <= bmmd_pkg::ADDR_LCD_HI)
                    o.target = bmmd_pkg::TGT_VIDEO;
                else if (a == bmmd_pkg::ADDR_KEY1)
                begin
                    // plain mode: reads give all ones, writes go out to the cartridge
                    if (color)
                        o.kind = bmmd_pkg::K_KEY1;
                    else if (wr)
                        o.target = bmmd_pkg::TGT_CART;
                    else
                        o.kind = bmmd_pkg::K_CONST_FF;
                end
                else if (a == bmmd_pkg::ADDR_VBK && color)
                    o.target = bmmd_pkg::TGT_VIDEO;
                else if (a == bmmd_pkg::ADDR_BOOT)
                    o.kind = bmmd_pkg::K_NONE;
                else if (a >= bmmd_pkg::ADDR_HDMA1 && a <= bmmd_pkg::ADDR_HDMA5 && color
                         && (wr || a == bmmd_pkg::ADDR_HDMA5))
                begin
                    if (a == bmmd_pkg::ADDR_HDMA1)
                        o.kind = bmmd_pkg::K_SRC_HI;
                    else if (a == bmmd_pkg::ADDR_HDMA2)
                        o.kind = bmmd_pkg::K_SRC_LO;
                    else if (a == bmmd_pkg::ADDR_HDMA3)
                        o.kind = bmmd_pkg::K_DST_HI;
                    else if (a == bmmd_pkg::ADDR_HDMA4)
                        o.kind = bmmd_pkg::K_DST_LO;
                    else
                        o.kind = bmmd_pkg::K_HDMA_CTRL;
                end
                else if (a >= bmmd_pkg::ADDR_PAL_LO && a <= bmmd_pkg::ADDR_PAL_HI && color)
                    o.target = bmmd_pkg::TGT_VIDEO;
                else if (a == bmmd_pkg::ADDR_SVBK && color)
                    o.kind = bmmd_pkg::K_SVBK;
                else if (a >= bmmd_pkg::ADDR_HRAM_LO && a <= bmmd_pkg::ADDR_HRAM_HI)
                    o.kind = bmmd_pkg::K_HRAM;
                else if (a == bmmd_pkg::ADDR_IE)
                    o.kind = bmmd_pkg::K_IE;
                else
                    o.target = bmmd_pkg::TGT_CART;
            end
        endcase
        return o;
    endfunction

    assign color_mode_next = cfg_we ? cfg_data : color_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= 1'b0;
        end
        else
        begin
            color_mode_reg <= color_mode_next;
        end
    end

    assign q_push = push && !q_full;
    assign q_op   = decode(req, color_mode_reg);

endmodule

// ----- design/bmmd_queue.sv -----
module bmmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  bmmd_pkg::op_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output bmmd_pkg::op_t rd_data,
    output logic          empty
);

    bmmd_pkg::op_t                   entry_reg [bmmd_pkg::QDEPTH];
    logic [bmmd_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [bmmd_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [bmmd_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                            do_wr;
    logic                            do_rd;

    assign full    = (count_reg == bmmd_pkg::QCNT_W'(bmmd_pkg::QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == bmmd_pkg::QPTR_W'(bmmd_pkg::QDEPTH - 1))
                        ? '0 : bmmd_pkg::QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == bmmd_pkg::QPTR_W'(bmmd_pkg::QDEPTH - 1))
                        ? '0 : bmmd_pkg::QPTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_wr && !do_rd)
            count_next = bmmd_pkg::QCNT_W'(count_reg + 1'b1);
        else if (do_rd && !do_wr)
            count_next = bmmd_pkg::QCNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- design/bmmd_back.sv -----
module bmmd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  bmmd_pkg::op_t  q_op,
    output logic           q_pop,
    input  logic           pop,
    output logic           empty,
    output bmmd_pkg::res_t res
);

    typedef enum logic [1:0] {
        SRC_REG,
        SRC_WRAM,
        SRC_HRAM
    } rd_src_t;

    logic [7:0] wram_mem [bmmd_pkg::WRAM_DEPTH];
    logic [7:0] hram_mem [bmmd_pkg::HRAM_BYTES];
    logic [7:0] wram_q_reg;
    logic [7:0] hram_q_reg;

    logic [2:0]  bank_sel_reg,  bank_sel_next;
    logic [4:0]  irq_en_reg,    irq_en_next;
    logic [4:0]  irq_flags_reg, irq_flags_next;
    logic        prep_reg,      prep_next;
    logic        dspeed_reg,    dspeed_next;
    logic [15:0] src_reg,       src_next;
    logic [15:0] dst_reg,       dst_next;
    logic [6:0]  blocks_reg,    blocks_next;
    logic        hblank_reg,    hblank_next;
    logic        stopped_reg,   stopped_next;

    logic           out_valid_reg, out_valid_next;
    bmmd_pkg::res_t out_res_reg,   out_res_next;
    rd_src_t        out_src_reg,   out_src_next;

    logic                         fire;
    logic [2:0]                   bank;
    logic [bmmd_pkg::WRAM_AW-1:0] wram_idx;
    logic [bmmd_pkg::HRAM_AW-1:0] hram_idx;
    logic                         wram_we, wram_re;
    logic                         hram_we, hram_re;
    logic [7:0]                   rd;
    rd_src_t                      rd_src;
    logic                         oam_start;
    logic [7:0]                   oam_page;

    // one request per cycle as long as the result slot frees up
    assign fire  = !q_empty && (!out_valid_reg || pop);
    assign q_pop = fire;
    assign empty = !out_valid_reg;

    assign bank     = q_op.addr[12] ? bmmd_pkg::bank_mod(bank_sel_reg) : 3'd0;
    assign wram_idx = {bank[bmmd_pkg::BANK_W-1:0], q_op.addr[11:0]};
    assign hram_idx = q_op.addr[bmmd_pkg::HRAM_AW-1:0];

    assign wram_we = fire && q_op.kind == bmmd_pkg::K_WRAM && q_op.wr;
    assign wram_re = fire && q_op.kind == bmmd_pkg::K_WRAM && !q_op.wr;
    assign hram_we = fire && q_op.kind == bmmd_pkg::K_HRAM && q_op.wr;
    assign hram_re = fire && q_op.kind == bmmd_pkg::K_HRAM && !q_op.wr;

    always_comb
    begin
        bank_sel_next  = bank_sel_reg;
        irq_en_next    = irq_en_reg;
        irq_flags_next = irq_flags_reg;
        prep_next      = prep_reg;
        dspeed_next    = dspeed_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        blocks_next    = blocks_reg;
        hblank_next    = hblank_reg;
        stopped_next   = stopped_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_src_next   = out_src_reg;
        rd             = 8'd0;
        rd_src         = SRC_REG;
        oam_start      = 1'b0;
        oam_page       = 8'd0;

        if (fire)
        begin
            case (q_op.kind)
                bmmd_pkg::K_CONST_FF:
                begin
                    rd = bmmd_pkg::RD_ALL_ONES;
                end
                bmmd_pkg::K_WRAM:
                begin
                    if (!q_op.wr)
                        rd_src = SRC_WRAM;
                end
                bmmd_pkg::K_HRAM:
                begin
                    if (!q_op.wr)
                        rd_src = SRC_HRAM;
                end
                bmmd_pkg::K_IF:
                begin
                    if (q_op.wr)
                        irq_flags_next = q_op.wdata[4:0];
                    else
                        rd = {3'd0, irq_flags_reg};
                end
                bmmd_pkg::K_IE:
                begin
                    if (q_op.wr)
                        irq_en_next = q_op.wdata[4:0];
                    else
                        rd = {3'd0, irq_en_reg};
                end
                bmmd_pkg::K_KEY1:
                begin
                    if (q_op.wr)
                    begin
                        if (q_op.wdata[0])
                            prep_next = 1'b1;
                    end
                    else
                        rd = {dspeed_reg, 6'd0, prep_reg};
                end
                bmmd_pkg::K_OAM:
                begin
                    oam_start = 1'b1;
                    oam_page  = (q_op.wdata >= bmmd_pkg::OAM_PAGE_MOD)
                              ? q_op.wdata - bmmd_pkg::OAM_PAGE_MOD : q_op.wdata;
                end
                bmmd_pkg::K_SRC_HI:
                begin
                    src_next = {q_op.wdata, src_reg[7:0]};
                end
                bmmd_pkg::K_SRC_LO:
                begin
                    src_next = {src_reg[15:8], q_op.wdata[7:4], 4'd0};
                end
                bmmd_pkg::K_DST_HI:
                begin
                    dst_next = {3'b100, q_op.wdata[4:0], dst_reg[7:0]};
                end
                bmmd_pkg::K_DST_LO:
                begin
                    dst_next = {dst_reg[15:8], q_op.wdata[7:4], 4'd0};
                end
                bmmd_pkg::K_HDMA_CTRL:
                begin
                    if (!q_op.wr)
                        rd = (blocks_reg == 7'd0) ? bmmd_pkg::RD_ALL_ONES
                                                  : {stopped_reg, blocks_reg};
                    else if (blocks_reg == 7'd0)
                    begin
                        hblank_next  = q_op.wdata[7];
                        blocks_next  = q_op.wdata[6:0];
                        stopped_next = 1'b0;
                    end
                    else
                        stopped_next = !q_op.wdata[7] && hblank_reg;
                end
                bmmd_pkg::K_SVBK:
                begin
                    if (q_op.wr)
                        bank_sel_next = (q_op.wdata[2:0] == 3'd0) ? bmmd_pkg::BANK_SEL_RST
                                                                  : q_op.wdata[2:0];
                    else
                        rd = {5'd0, bank_sel_reg};
                end
                bmmd_pkg::K_SPEED:
                begin
                    if (prep_reg)
                    begin
                        prep_next   = 1'b0;
                        dspeed_next = !dspeed_reg;
                    end
                end
                bmmd_pkg::K_HDMA_DONE:
                begin
                    if (blocks_reg != 7'd0 && !stopped_reg)
                        blocks_next = hblank_reg ? 7'(blocks_reg - 1'b1) : 7'd0;
                end
                default:
                begin
                end
            endcase

            irq_flags_next = irq_flags_next | q_op.irq_raise;

            out_valid_next                = 1'b1;
            out_src_next                  = rd_src;
            out_res_next.rdata            = rd;
            out_res_next.target           = q_op.target;
            out_res_next.oam_dma_start    = oam_start;
            out_res_next.oam_dma_page     = oam_page;
            out_res_next.double_speed_out = dspeed_next;
            out_res_next.hdma_src_out     = src_next;
            out_res_next.hdma_dst_out     = dst_next;
            out_res_next.hdma_blocks_out  = blocks_next;
            out_res_next.hdma_hblank_out  = hblank_next;
            out_res_next.hdma_stopped_out = stopped_next;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_sel_reg  <= bmmd_pkg::BANK_SEL_RST;
            irq_en_reg    <= '0;
            irq_flags_reg <= '0;
            prep_reg      <= 1'b0;
            dspeed_reg    <= 1'b0;
            src_reg       <= '0;
            dst_reg       <= bmmd_pkg::HDMA_DST_RST;
            blocks_reg    <= '0;
            hblank_reg    <= 1'b0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bank_sel_reg  <= bank_sel_next;
            irq_en_reg    <= irq_en_next;
            irq_flags_reg <= irq_flags_next;
            prep_reg      <= prep_next;
            dspeed_reg    <= dspeed_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            blocks_reg    <= blocks_next;
            hblank_reg    <= hblank_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
        out_src_reg <= out_src_next;
    end

    // RAM read data holds until the next read, which waits for the result slot
    always_ff @(posedge clk)
    begin
        if (wram_we)
            wram_mem[wram_idx] <= q_op.wdata;
        if (wram_re)
            wram_q_reg <= wram_mem[wram_idx];
    end

    always_ff @(posedge clk)
    begin
        if (hram_we)
            hram_mem[hram_idx] <= q_op.wdata;
        if (hram_re)
            hram_q_reg <= hram_mem[hram_idx];
    end

    always_comb
    begin
        res = out_res_reg;
        case (out_src_reg)
            SRC_WRAM: res.rdata = wram_q_reg;
            SRC_HRAM: res.rdata = hram_q_reg;
            default:  res.rdata = out_res_reg.rdata;
        endcase
    end

endmodule

// ----- design/banked_memory_map_decoder.sv -----
// Memory-map decoder for a 16-bit CPU bus with banked work RAM.
//
// Request side is a queue: present req and raise push; the request is taken
// at a clock edge where push is high and full is low. Each request is a read,
// a write, a speed-switch event or an HDMA block-done notice.
// Result side is a queue too: while empty is low, res holds the oldest result
// (read data, routing target, sprite DMA pulse, speed and VRAM DMA state);
// it is taken at an edge where pop is high and empty is low.
// cfg_we/cfg_data write color_mode; change it only when idle.
//
// An accepted request passes the front/back queue, then the result register.
// Throughput: one request per cycle while results are popped, set by the
// single-port work/high RAM access in the back end (one access per request).
// A stalled result holds steady; the 2-entry front/back queue absorbs new
// requests and full rises once it is taken up.
// Reset clears the control registers and both queues (empty high, full low);
// the result payload and work/high RAM contents are undefined until written.
module banked_memory_map_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_data,
    input  logic              push,
    output logic              full,
    input  bmmd_pkg::in_req_t req,
    output logic              empty,
    input  logic              pop,
    output bmmd_pkg::res_t    res
);

    logic          q_push;
    bmmd_pkg::op_t q_in_op;
    logic          q_full;
    logic          q_pop;
    bmmd_pkg::op_t q_out_op;
    logic          q_empty;

    // decode and classify, holds color_mode
    bmmd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .push     (push),
        .req      (req),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (q_in_op)
    );

    // decouples decode from execution
    bmmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_in_op),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_out_op),
        .empty   (q_empty)
    );

    // registers, RAMs and the result register
    bmmd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_op    (q_out_op),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign full = q_full;

endmodule

// ----- design/bmmd_checker.sv -----
module bmmd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input bmmd_pkg::res_t    res
);

    // both queues come up empty
    assert property (@(posedge clk) !rst_n |-> empty && !full)
        else $error("queues not clear in reset");

    // a waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(res))
        else $error("stalled result changed");

    // sprite DMA start is an internal access with a legal page
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && res.oam_dma_start |->
            res.target == bmmd_pkg::TGT_INTERNAL && res.oam_dma_page < bmmd_pkg::OAM_PAGE_MOD)
        else $error("bad sprite DMA result");

    // VRAM DMA addresses stay aligned, destination inside video RAM
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> res.hdma_dst_out[15:13] == 3'b100 && res.hdma_dst_out[3:0] == 4'd0
                   && res.hdma_src_out[3:0] == 4'd0)
        else $error("VRAM DMA address misaligned");

    // only a running hblank transfer can be stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && res.hdma_stopped_out |->
            res.hdma_blocks_out != 7'd0 && res.hdma_hblank_out)
        else $error("stopped flag without hblank transfer");

endmodule

bind banked_memory_map_decoder bmmd_checker u_bmmd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .res      (res)
);
